>>> design/bfvd_pkg.sv
// ---------------------------------------------------------------------------
// bfvd_pkg
// Shared types, frame geometry and the block-mean helper for the box filter
// video downscaler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfvd_pkg;

	localparam int NARROW_COL_BLOCKS = 96;
	localparam int WIDE_COL_BLOCKS   = 80;
	localparam int SHORT_ROW_BANDS   = 36;
	localparam int TALL_ROW_BANDS    = 108;

	localparam int TOTAL_BLOCKS = NARROW_COL_BLOCKS + WIDE_COL_BLOCKS;
	localparam int TOTAL_BANDS  = SHORT_ROW_BANDS + TALL_ROW_BANDS;

	localparam int NARROW_W = 5;
	localparam int WIDE_W   = 6;
	localparam int SHORT_H  = 3;
	localparam int TALL_H   = 4;

	localparam int CH_BITS    = 13;
	localparam int BLK_BITS   = 8;
	localparam int BAND_BITS  = 8;
	localparam int COL_BITS   = 3;
	localparam int ROW_BITS   = 2;
	localparam int RECIP_SH   = 20;
	localparam int RECIP_BITS = 17;

	localparam logic [BLK_BITS-1:0]  LAST_BLOCK    = BLK_BITS'(TOTAL_BLOCKS - 1);
	localparam logic [BLK_BITS-1:0]  LAST_NARROW   = BLK_BITS'(NARROW_COL_BLOCKS - 1);
	localparam logic [BAND_BITS-1:0] LAST_BAND     = BAND_BITS'(TOTAL_BANDS - 1);
	localparam logic [BAND_BITS-1:0] LAST_SHORT    = BAND_BITS'(SHORT_ROW_BANDS - 1);
	localparam logic [COL_BITS-1:0]  NARROW_LAST_C = COL_BITS'(NARROW_W - 1);
	localparam logic [COL_BITS-1:0]  WIDE_LAST_C   = COL_BITS'(WIDE_W - 1);
	localparam logic [ROW_BITS-1:0]  SHORT_LAST_R  = ROW_BITS'(SHORT_H - 1);
	localparam logic [ROW_BITS-1:0]  TALL_LAST_R   = ROW_BITS'(TALL_H - 1);

	// rounded-up reciprocals of the four block areas, scaled by 2^RECIP_SH
	localparam logic [RECIP_BITS-1:0] RECIP_NS =
		RECIP_BITS'(((1 << RECIP_SH) + NARROW_W * SHORT_H - 1) / (NARROW_W * SHORT_H));
	localparam logic [RECIP_BITS-1:0] RECIP_WS =
		RECIP_BITS'(((1 << RECIP_SH) + WIDE_W * SHORT_H - 1) / (WIDE_W * SHORT_H));
	localparam logic [RECIP_BITS-1:0] RECIP_NT =
		RECIP_BITS'(((1 << RECIP_SH) + NARROW_W * TALL_H - 1) / (NARROW_W * TALL_H));
	localparam logic [RECIP_BITS-1:0] RECIP_WT =
		RECIP_BITS'(((1 << RECIP_SH) + WIDE_W * TALL_H - 1) / (WIDE_W * TALL_H));

	typedef logic [CH_BITS-1:0] ch_sum_t;

	typedef struct packed {
		ch_sum_t blue;
		ch_sum_t green;
		ch_sum_t red;
	} rgb_sum_t;

	typedef struct packed {
		logic                first_col;
		logic                first_row;
		logic                last_col;
		logic                last;
		logic                wide;
		logic                tall;
		logic                row_end;
		logic                frame_end;
		logic                filt;
		logic [BLK_BITS-1:0] blk;
	} px_ctl_t;

	// block mean (or raw sum when not filtering), clamped to a byte
	function automatic logic [7:0] block_value(input ch_sum_t t, input logic wide,
			input logic tall, input logic filt);
		logic [RECIP_BITS-1:0]         recip;
		logic [CH_BITS+RECIP_BITS-1:0] prod;
		logic [CH_BITS-1:0]            q;
		case ({wide, tall})
			2'b00:   recip = RECIP_NS;
			2'b10:   recip = RECIP_WS;
			2'b01:   recip = RECIP_NT;
			2'b11:   recip = RECIP_WT;
			default: recip = RECIP_NS;
		endcase
		prod = (CH_BITS + RECIP_BITS)'(t) * (CH_BITS + RECIP_BITS)'(recip);
		if (filt)
			q = CH_BITS'(prod[CH_BITS+RECIP_BITS-1:RECIP_SH]);
		else
			q = t;
		if (q > CH_BITS'(255))
			return 8'hff;
		else
			return q[7:0];
	endfunction

endpackage

>>> design/box_filter_video_downscaler_unit.sv
// ---------------------------------------------------------------------------
// box_filter_video_downscaler_unit
// Box-filter downscaler from a 960x540 RGB raster stream to a 176x144 frame.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Takes one pixel per clock unless in_stall is high and presents one output
// pixel on the bottom-right pixel of each block. When filtering, each row's
// pixels of a block are summed in a running register; the 176-entry
// column-sum memory is read once at the block's first column and written
// once at its last, so its single read and single write port never limit
// the rate. The block mean is a reciprocal multiply per channel in the last
// stage; unfiltered, the block's top-left pixel passes. No clearing pass is
// needed after reset: each band's first row loads its entry before it is read.
module box_filter_video_downscaler_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic       frame_start,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic       row_end,
	output logic       frame_end
);
	import bfvd_pkg::*;

	logic filt_q;

	logic [COL_BITS-1:0]  col_q;
	logic [BLK_BITS-1:0]  blk_q;
	logic [ROW_BITS-1:0]  row_q;
	logic [BAND_BITS-1:0] band_q;

	logic [COL_BITS-1:0]  col_c;
	logic [BLK_BITS-1:0]  blk_c;
	logic [ROW_BITS-1:0]  row_c;
	logic [BAND_BITS-1:0] band_c;
	logic [COL_BITS-1:0]  last_col_c;
	logic [ROW_BITS-1:0]  last_row_c;
	px_ctl_t              ctl_c;

	logic     s2_free, s1_free, adv_out, adv_s1, accept;
	logic     v_s1, v_s2, v_s3;
	px_ctl_t  ctl_s1;
	rgb_sum_t px_s1;

	rgb_sum_t hacc_q;
	rgb_sum_t rd_q;
	rgb_sum_t hsum, total;
	rgb_sum_t col_sums [TOTAL_BLOCKS];

	rgb_sum_t tot_s2;
	logic     wide_s2, tall_s2, filt_s2, row_end_s2, frame_end_s2;

	logic [7:0] red_s3, green_s3, blue_s3;
	logic       row_end_s3, frame_end_s3;

	// handshake
	assign adv_out  = !v_s3 || !out_stall;
	assign s2_free  = !v_s2 || adv_out;
	assign adv_s1   = v_s1 && s2_free;
	assign s1_free  = !v_s1 || s2_free;
	assign in_stall = !s1_free;
	assign accept   = in_valid && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= 1'b1;
		end else if (cfg_wr_en) begin
			filt_q <= cfg_wr_data;
		end
	end

	// position of the incoming pixel, frame_start restarts it
	always_comb begin
		col_c  = frame_start ? '0 : col_q;
		blk_c  = frame_start ? '0 : blk_q;
		row_c  = frame_start ? '0 : row_q;
		band_c = frame_start ? '0 : band_q;

		last_col_c = (blk_c > LAST_NARROW) ? WIDE_LAST_C : NARROW_LAST_C;
		last_row_c = (band_c > LAST_SHORT) ? TALL_LAST_R : SHORT_LAST_R;

		ctl_c.first_col = (col_c == '0);
		ctl_c.first_row = (row_c == '0);
		ctl_c.last_col  = (col_c == last_col_c);
		ctl_c.last      = (col_c == last_col_c) && (row_c == last_row_c);
		ctl_c.wide      = (blk_c > LAST_NARROW);
		ctl_c.tall      = (band_c > LAST_SHORT);
		ctl_c.row_end   = (blk_c == LAST_BLOCK);
		ctl_c.frame_end = (blk_c == LAST_BLOCK) && (band_c == LAST_BAND);
		ctl_c.filt      = filt_q;
		ctl_c.blk       = blk_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			blk_q  <= '0;
			row_q  <= '0;
			band_q <= '0;
		end else if (accept) begin
			if (col_c == last_col_c) begin
				col_q <= '0;
				if (blk_c == LAST_BLOCK) begin
					blk_q <= '0;
					if (row_c == last_row_c) begin
						row_q  <= '0;
						band_q <= (band_c == LAST_BAND) ? '0 : band_c + 1'b1;
					end else begin
						row_q  <= row_c + 1'b1;
						band_q <= band_c;
					end
				end else begin
					blk_q  <= blk_c + 1'b1;
					row_q  <= row_c;
					band_q <= band_c;
				end
			end else begin
				col_q  <= col_c + 1'b1;
				blk_q  <= blk_c;
				row_q  <= row_c;
				band_q <= band_c;
			end
		end
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1    <= ctl_c;
			px_s1.red   <= CH_BITS'(red_in);
			px_s1.green <= CH_BITS'(green_in);
			px_s1.blue  <= CH_BITS'(blue_in);
		end
	end

	// sums of earlier rows of the block, fetched at the block's first column
	always_ff @(posedge clk) begin
		if (accept && ctl_c.first_col) begin
			rd_q <= col_sums[blk_c];
		end
	end

	// running row sum and block total
	always_comb begin
		if (ctl_s1.first_col) begin
			hsum = (ctl_s1.first_row || ctl_s1.filt) ? px_s1 : '0;
		end else if (ctl_s1.filt) begin
			hsum.red   = hacc_q.red + px_s1.red;
			hsum.green = hacc_q.green + px_s1.green;
			hsum.blue  = hacc_q.blue + px_s1.blue;
		end else begin
			hsum = hacc_q;
		end
		if (ctl_s1.first_row) begin
			total = hsum;
		end else begin
			total.red   = rd_q.red + hsum.red;
			total.green = rd_q.green + hsum.green;
			total.blue  = rd_q.blue + hsum.blue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			hacc_q <= hsum;
		end
	end

	// write back on the block's last column of each row
	always_ff @(posedge clk) begin
		if (adv_s1 && ctl_s1.last_col) begin
			col_sums[ctl_s1.blk] <= total;
		end
	end

	// stage 2: block total of a finished block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= adv_s1 && ctl_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && ctl_s1.last) begin
			tot_s2       <= total;
			wide_s2      <= ctl_s1.wide;
			tall_s2      <= ctl_s1.tall;
			filt_s2      <= ctl_s1.filt;
			row_end_s2   <= ctl_s1.row_end;
			frame_end_s2 <= ctl_s1.frame_end;
		end
	end

	// stage 3: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_out) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s2) begin
			red_s3       <= block_value(tot_s2.red, wide_s2, tall_s2, filt_s2);
			green_s3     <= block_value(tot_s2.green, wide_s2, tall_s2, filt_s2);
			blue_s3      <= block_value(tot_s2.blue, wide_s2, tall_s2, filt_s2);
			row_end_s3   <= row_end_s2;
			frame_end_s3 <= frame_end_s2;
		end
	end

	assign out_valid = v_s3;
	assign red_out   = red_s3;
	assign green_out = green_s3;
	assign blue_out  = blue_s3;
	assign row_end   = row_end_s3;
	assign frame_end = frame_end_s3;

endmodule
